[hdl/spq_pkg.sv]
// Package for the sorted priority queue: sizes, operation and status codes,
// and the packed transfer types of both channels. Depends on nothing.
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CAP_W = 5;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int OCC_W = 5;
   localparam int VAL_W = 32;
   localparam int PRI_W = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic [CSR_AW-1:0] CSR_ADDR_CAPACITY = '0;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_DISPLAY = 2'd2;
   localparam logic [1:0] OP_INVALID = 2'd3;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_FULL    = 2'd1;
   localparam logic [1:0] STS_EMPTY   = 2'd2;
   localparam logic [1:0] STS_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]              opcode;
      logic signed [VAL_W-1:0] item_value;
      logic [PRI_W-1:0]        item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] out_value;
      logic [PRI_W-1:0]        out_priority;
      logic [OCC_W-1:0]        occupancy;
      logic                    last_of_run;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;      // take the input transfer and update the store
      logic disp_load;   // load the next displayed entry into the output
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic queue_empty;
      logic disp_last;
   } sts_type;

endpackage

[hdl/spq_ctrl.sv]
// Controller of the sorted priority queue: idle/display state machine and
// output valid. Depends on spq_pkg.
module spq_ctrl
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SHOW = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The output register can take a new transfer when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd.accept    = 1'b0;
      cmd.disp_load = 1'b0;
      req_stall     = 1'b1;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (out_free && req_valid) begin
               cmd.accept = 1'b1;
               if (req_opcode == OP_DISPLAY && !sts.queue_empty) begin
                  state_in = ST_SHOW;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SHOW: begin
            if (out_free) begin
               cmd.disp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               if (sts.disp_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/spq_datapath.sv]
// Datapath of the sorted priority queue: entry registers with parallel
// compare and shift, count, capacity register and output register.
// Depends on spq_pkg.
module spq_datapath
   import spq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   output rsp_type           rsp_data,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata
);

   logic signed [VAL_W-1:0] entry_val_ff [DEPTH];
   logic signed [VAL_W-1:0] entry_val_in [DEPTH];
   logic [PRI_W-1:0]        entry_pri_ff [DEPTH];
   logic [PRI_W-1:0]        entry_pri_in [DEPTH];
   logic [DEPTH-1:0]        ins_mask;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    full, empty, enq_ok, deq_ok;
   logic                    cap_hit;

   assign empty = (count_ff == '0);
   assign full  = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) || (count_ff == CNT_W'(DEPTH));
   assign enq_ok = cmd.accept && req_data.opcode == OP_ENQUEUE && !full;
   assign deq_ok = cmd.accept && req_data.opcode == OP_DEQUEUE && !empty;

   // Slots at or after the insertion point: stored entries of greater
   // priority number, and the first free slot.
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         if (count_ff > CNT_W'(k)) begin
            ins_mask[k] = entry_pri_ff[k] > req_data.item_priority;
         end else begin
            ins_mask[k] = (count_ff == CNT_W'(k));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         entry_val_in[k] = entry_val_ff[k];
         entry_pri_in[k] = entry_pri_ff[k];
         if (enq_ok && ins_mask[k]) begin
            if (k == 0 || !ins_mask[(k == 0) ? 0 : k - 1]) begin
               entry_val_in[k] = req_data.item_value;
               entry_pri_in[k] = req_data.item_priority;
            end else begin
               entry_val_in[k] = entry_val_ff[(k == 0) ? 0 : k - 1];
               entry_pri_in[k] = entry_pri_ff[(k == 0) ? 0 : k - 1];
            end
         end else if (deq_ok && k < DEPTH - 1) begin
            entry_val_in[k] = entry_val_ff[(k < DEPTH - 1) ? k + 1 : k];
            entry_pri_in[k] = entry_pri_ff[(k < DEPTH - 1) ? k + 1 : k];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign sts.queue_empty = empty;
   assign sts.disp_last   = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.disp_load) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.out_value    = '0;
      rsp_in.out_priority = '0;
      rsp_in.occupancy    = OCC_W'(count_in);
      rsp_in.last_of_run  = 1'b1;
      rsp_in.status       = STS_OK;
      if (cmd.disp_load) begin
         rsp_in.out_value    = entry_val_ff[idx_ff];
         rsp_in.out_priority = entry_pri_ff[idx_ff];
         rsp_in.last_of_run  = sts.disp_last;
      end else begin
         case (req_data.opcode)
            OP_ENQUEUE: begin
               if (full) begin
                  rsp_in.status = STS_FULL;
               end
            end
            OP_DEQUEUE: begin
               if (empty) begin
                  rsp_in.status = STS_EMPTY;
               end else begin
                  rsp_in.out_value    = entry_val_ff[0];
                  rsp_in.out_priority = entry_pri_ff[0];
               end
            end
            OP_DISPLAY: begin
               rsp_in.status = STS_EMPTY;
            end
            OP_INVALID: begin
               rsp_in.status = STS_INVALID;
            end
            default: begin
               rsp_in.status = STS_INVALID;
            end
         endcase
      end
   end

   // Configuration register; only word address zero is implemented.
   assign cap_hit = (csr_paddr[CSR_AW-1:2] == CSR_ADDR_CAPACITY[CSR_AW-1:2]);

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && cap_hit) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = cap_hit ? CSR_DW'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         entry_val_ff[k] <= entry_val_in[k];
         entry_pri_ff[k] <= entry_pri_in[k];
      end
      if (cmd.accept || cmd.disp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[hdl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: joins the controller and the
// datapath. Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   Channel   Prefix  Direction  Carries
//   input     req_    in         one operation: opcode, value, priority
//   result    rsp_    out        status, value, priority, occupancy, last flag
//   config    csr_    in/out     capacity limit register at byte address 0
//
// Enqueue, dequeue, invalid and empty-queue display operations are answered
// at once: the result is registered at the edge at which the input transfer
// is taken, and a new input transfer can follow in the next cycle. Display
// of a non-empty queue loads its entries in order through the single read
// port of the entry store. Reset empties the queue and sets the capacity
// limit to 16; there is no clearing pass. A stalled result holds the output
// register, and further input transfers wait until it drains.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cmd_type cmd;
   sts_type sts;

   // The register file answers in the access cycle, so no wait states.
   assign csr_pready = 1'b1;

   // The controller sequences transfers and display runs.
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the sorted entries, count, capacity and output.
   spq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule
